>>> hdl/brb_pkg.sv
// package for the byte ring buffer with peek
// holds action codes, controller states, command struct and default sizes
// no dependencies
package brb_pkg;

  // default ring size as log2 of the slot count
  localparam int DEPTH_LOG2_DEF = 8;

  // payload widths fixed by the item format
  localparam int ACT_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 8;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_SKIP = 2'd3
  } action_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // latch the accepted input beat
    logic exec;  // perform the action on pointers and ram
  } cmd_t;

endpackage

>>> hdl/brb_if.sv
// channel interfaces for the byte ring buffer: input beat and result beat
// depends on brb_pkg for payload widths
interface brb_in_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::ACT_W-1:0]  action;
  logic [brb_pkg::BYTE_W-1:0] push_byte;
  logic [brb_pkg::CNT_W-1:0]  offset_or_count;

  modport source (output valid, action, push_byte, offset_or_count, input ready);
  modport sink   (input valid, action, push_byte, offset_or_count, output ready);
endinterface

interface brb_out_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::BYTE_W-1:0] read_byte;
  logic                       ok;
  logic [brb_pkg::CNT_W-1:0]  skipped;
  logic [brb_pkg::CNT_W-1:0]  fill_count;
  logic                       is_empty;
  logic                       is_full;

  modport source (output valid, read_byte, ok, skipped, fill_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, read_byte, ok, skipped, fill_count, is_empty, is_full,
                  output ready);
endinterface

>>> hdl/brb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/brb_ctrl.sv
// controller for the byte ring buffer: accept, execute, present result
// depends on brb_pkg for state and command types
module brb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output brb_pkg::cmd_t cmd
);

  brb_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      brb_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = brb_pkg::ST_EXEC;
        end
      end
      brb_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = brb_pkg::ST_OUT;
      end
      brb_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/brb_dp.sv
// datapath for the byte ring buffer: pointers, byte store, result registers
// depends on brb_pkg and brb_ram
module brb_dp #(
  parameter int DEPTH_LOG2 = brb_pkg::DEPTH_LOG2_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  brb_pkg::cmd_t              cmd,
  input  logic [brb_pkg::ACT_W-1:0]  action,
  input  logic [brb_pkg::BYTE_W-1:0] push_byte,
  input  logic [brb_pkg::CNT_W-1:0]  offset_or_count,
  output logic [brb_pkg::BYTE_W-1:0] read_byte,
  output logic                       ok,
  output logic [brb_pkg::CNT_W-1:0]  skipped,
  output logic [brb_pkg::CNT_W-1:0]  fill_count,
  output logic                       is_empty,
  output logic                       is_full
);

  localparam int AW = DEPTH_LOG2;
  // compare width wide enough for both the count field and the fill level
  localparam int CW = (AW > brb_pkg::CNT_W) ? AW : brb_pkg::CNT_W;
  localparam logic [AW-1:0] FULL_LVL = {AW{1'b1}};

  // latched input beat
  brb_pkg::action_t           act;
  logic [brb_pkg::BYTE_W-1:0] data;
  logic [brb_pkg::CNT_W-1:0]  arg;

  // ring pointers
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] rp, rp_next;

  // ram controls
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [brb_pkg::BYTE_W-1:0] ram_q;

  // action results
  logic          ok_next, hit_next;
  logic [CW-1:0] fill_ext, arg_ext, skip_ext, fill_after_ext;
  logic [AW-1:0] fill_cur, fill_after;
  logic          hit;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= brb_pkg::action_t'(action);
      data <= push_byte;
      arg  <= offset_or_count;
    end
  end

  // action decode
  always_comb begin
    fill_cur  = wp - rp;
    fill_ext  = CW'(fill_cur);
    arg_ext   = CW'(arg);
    skip_ext  = '0;
    wp_next   = wp;
    rp_next   = rp;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp;
    ok_next   = 1'b0;
    hit_next  = 1'b0;
    case (act)
      brb_pkg::ACT_PUSH: begin
        if (fill_cur != FULL_LVL) begin
          ram_we  = cmd.exec;
          wp_next = wp + AW'(1);
          ok_next = 1'b1;
        end
      end
      brb_pkg::ACT_POP: begin
        if (fill_cur != '0) begin
          ram_re   = cmd.exec;
          rp_next  = rp + AW'(1);
          ok_next  = 1'b1;
          hit_next = 1'b1;
        end
      end
      brb_pkg::ACT_PEEK: begin
        ram_raddr = rp + AW'(arg);
        if (arg_ext < fill_ext) begin
          ram_re   = cmd.exec;
          ok_next  = 1'b1;
          hit_next = 1'b1;
        end
      end
      brb_pkg::ACT_SKIP: begin
        // clip the count to the fill level
        skip_ext = (arg_ext > fill_ext) ? fill_ext : arg_ext;
        rp_next  = rp + AW'(skip_ext);
        ok_next  = (skip_ext != '0);
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    fill_after     = wp_next - rp_next;
    fill_after_ext = CW'(fill_after);
  end

  // pointers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      hit        <= 1'b0;
      ok         <= 1'b0;
      skipped    <= '0;
      fill_count <= '0;
      is_empty   <= 1'b1;
      is_full    <= 1'b0;
    end else if (cmd.exec) begin
      wp         <= wp_next;
      rp         <= rp_next;
      hit        <= hit_next;
      ok         <= ok_next;
      skipped    <= skip_ext[brb_pkg::CNT_W-1:0];
      // saturate the reported count on rings above 255 bytes
      fill_count <= (fill_after_ext > CW'(255)) ? brb_pkg::CNT_W'(255)
                                                : fill_after_ext[brb_pkg::CNT_W-1:0];
      is_empty   <= (fill_after == '0);
      is_full    <= (fill_after == FULL_LVL);
    end
  end

  // byte store
  brb_ram #(
    .WIDTH(brb_pkg::BYTE_W),
    .DEPTH(1 << AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(data),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // ram data is valid only after a successful pop or peek
  assign read_byte = hit ? ram_q : '0;

  // pointers move only while executing
  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(wp) && $stable(rp))
    else $error("pointer moved outside execute");

  // a successful push advances the write pointer by one
  a_push_step: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && ram_we |=> wp == $past(wp) + AW'(1))
    else $error("push did not advance write pointer");

  // empty and full flags never together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !(is_empty && is_full))
    else $error("empty and full both set");

  // a nonzero skip always reports success
  a_skip_ok: assert property (@(posedge clk) disable iff (rst)
    skipped != '0 |-> ok)
    else $error("skip reported bytes without ok");

endmodule

>>> hdl/byte_ring_buffer_with_peek.sv
// top level of the byte ring buffer with peek and skip
// depends on brb_pkg, brb_if, brb_ctrl, brb_dp and brb_ram
//
// A ring of 2**DEPTH_LOG2 byte slots that holds at most 2**DEPTH_LOG2 - 1
// bytes. Each input beat carries one action (push, pop, peek, skip) and gives
// exactly one result beat with the byte read, success flag, skipped count,
// fill count (saturated at 255) and empty/full flags. One item is in flight
// at a time: a beat is accepted, the next cycle performs the action through
// the write or read port of the byte store, and the result is offered the
// cycle after. The store is not cleared at reset; only bytes that were
// written are ever returned, so the block is ready right after reset.
module byte_ring_buffer_with_peek #(
  parameter int DEPTH_LOG2 = brb_pkg::DEPTH_LOG2_DEF
) (
  input logic       clk,
  input logic       rst,
  brb_in_if.sink    in_ch,
  brb_out_if.source out_ch
);

  brb_pkg::cmd_t cmd;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd)
  );

  brb_dp #(
    .DEPTH_LOG2(DEPTH_LOG2)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (in_ch.action),
    .push_byte      (in_ch.push_byte),
    .offset_or_count(in_ch.offset_or_count),
    .read_byte      (out_ch.read_byte),
    .ok             (out_ch.ok),
    .skipped        (out_ch.skipped),
    .fill_count     (out_ch.fill_count),
    .is_empty       (out_ch.is_empty),
    .is_full        (out_ch.is_full)
  );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for byte_ring_buffer_with_peek
// depends on brb_pkg, brb_in_if / brb_out_if and the ring buffer rtl
// a directed table then random push/pop/peek/skip traffic, checked against table entries or a ring predictor
module tb;

  localparam int RING_LOG2   = brb_pkg::DEPTH_LOG2_DEF;
  localparam int RING_SLOTS  = 1 << RING_LOG2;
  localparam int RANDOM_OPS  = 1430;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;

  // one result beat as the block reports it
  typedef struct packed {
    logic [brb_pkg::BYTE_W-1:0] rd_byte;
    logic                       ok;
    logic [brb_pkg::CNT_W-1:0]  skipped;
    logic [brb_pkg::CNT_W-1:0]  fill;
    logic                       empty;
    logic                       full;
  } ring_result_t;

  // one row of the directed table
  typedef struct packed {
    brb_pkg::action_t           act;
    logic [brb_pkg::BYTE_W-1:0] data;
    logic [brb_pkg::CNT_W-1:0]  arg;
    logic                       typed;
    ring_result_t               res;
  } stim_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  logic clk;
  logic rst;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  byte_ring_buffer_with_peek #(
    .DEPTH_LOG2(RING_LOG2)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor copy of the ring
  logic [brb_pkg::BYTE_W-1:0] ring_mem [RING_SLOTS];
  int                         head_ptr;
  int                         tail_ptr;

  ring_result_t      pending_results [$];
  int                mismatches;
  int                results_taken;

  // directed table: empty-ring errors, byte extremes, peek range edges, skip clipping
  stim_row_t directed_rows [24] = '{
    '{brb_pkg::ACT_POP,  8'h3c, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{brb_pkg::ACT_PEEK, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{brb_pkg::ACT_SKIP, 8'h00, 8'hff, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{brb_pkg::ACT_SKIP, 8'hff, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{brb_pkg::ACT_PUSH, 8'h00, 8'hff, 1'b1, '{8'h00, 1'b1, 8'h00, 8'h01, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PUSH, 8'hff, 8'h00, 1'b1, '{8'h00, 1'b1, 8'h00, 8'h02, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PUSH, 8'ha5, 8'h5a, 1'b1, '{8'h00, 1'b1, 8'h00, 8'h03, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PUSH, 8'h5a, 8'ha5, 1'b0, '0},
    '{brb_pkg::ACT_PEEK, 8'h11, 8'h00, 1'b1, '{8'h00, 1'b1, 8'h00, 8'h04, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PEEK, 8'h00, 8'h01, 1'b1, '{8'hff, 1'b1, 8'h00, 8'h04, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PEEK, 8'h00, 8'h03, 1'b0, '0},
    '{brb_pkg::ACT_PEEK, 8'h00, 8'h04, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h04, 1'b0, 1'b0}},
    '{brb_pkg::ACT_PEEK, 8'hff, 8'hff, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h04, 1'b0, 1'b0}},
    '{brb_pkg::ACT_SKIP, 8'h80, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h04, 1'b0, 1'b0}},
    '{brb_pkg::ACT_POP,  8'h77, 8'h80, 1'b1, '{8'h00, 1'b1, 8'h00, 8'h03, 1'b0, 1'b0}},
    '{brb_pkg::ACT_SKIP, 8'h00, 8'h01, 1'b0, '0},
    '{brb_pkg::ACT_POP,  8'h00, 8'h00, 1'b0, '0},
    '{brb_pkg::ACT_SKIP, 8'h00, 8'hff, 1'b1, '{8'h00, 1'b1, 8'h01, 8'h00, 1'b1, 1'b0}},
    '{brb_pkg::ACT_PUSH, 8'h81, 8'h00, 1'b0, '0},
    '{brb_pkg::ACT_PUSH, 8'h7e, 8'h00, 1'b0, '0},
    '{brb_pkg::ACT_SKIP, 8'h00, 8'hff, 1'b0, '0},
    '{brb_pkg::ACT_PUSH, 8'h33, 8'h00, 1'b0, '0},
    '{brb_pkg::ACT_POP,  8'h00, 8'h00, 1'b0, '0},
    '{brb_pkg::ACT_POP,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ring_held();
    return (head_ptr - tail_ptr + RING_SLOTS) % RING_SLOTS;
  endfunction

  // apply one action to the predictor and return the result it should give
  function automatic ring_result_t ring_step(brb_pkg::action_t act,
                                             logic [brb_pkg::BYTE_W-1:0] data,
                                             logic [brb_pkg::CNT_W-1:0] arg);
    ring_result_t r;
    int           held;
    int           a;
    int           cnt;
    r    = '0;
    held = ring_held();
    a    = int'(arg);
    case (act)
      brb_pkg::ACT_PUSH: begin
        if (held != RING_SLOTS - 1) begin
          ring_mem[RING_LOG2'(head_ptr)] = data;
          head_ptr = (head_ptr + 1) % RING_SLOTS;
          r.ok = 1'b1;
        end
      end
      brb_pkg::ACT_POP: begin
        if (held != 0) begin
          r.rd_byte = ring_mem[RING_LOG2'(tail_ptr)];
          tail_ptr = (tail_ptr + 1) % RING_SLOTS;
          r.ok = 1'b1;
        end
      end
      brb_pkg::ACT_PEEK: begin
        if (a < held) begin
          r.rd_byte = ring_mem[RING_LOG2'((tail_ptr + a) % RING_SLOTS)];
          r.ok = 1'b1;
        end
      end
      default: begin
        // skip count clipped to what is held
        cnt = (a > held) ? held : a;
        tail_ptr = (tail_ptr + cnt) % RING_SLOTS;
        r.skipped = cnt[brb_pkg::CNT_W-1:0];
        r.ok = (cnt != 0);
      end
    endcase
    held = ring_held();
    r.fill  = (held > 255) ? 8'd255 : held[brb_pkg::CNT_W-1:0];
    r.empty = (held == 0);
    r.full  = (held == RING_SLOTS - 1);
    return r;
  endfunction

  // idle cycles before a beat: stretches of back-to-back beats between random gaps
  function automatic int draw_gap(inout int stretch, inout bit calm);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 60);
      calm    = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  int send_stretch;
  bit send_calm;

  // offer one beat, wait for it to be taken, then predict its result
  task automatic send_action(input brb_pkg::action_t act,
                             input logic [brb_pkg::BYTE_W-1:0] data,
                             input logic [brb_pkg::CNT_W-1:0] arg, input bit typed,
                             input ring_result_t typed_res);
    int           gap;
    ring_result_t predicted;
    gap = draw_gap(send_stretch, send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= act;
    in_ch.push_byte       <= data;
    in_ch.offset_or_count <= arg;
    do @(posedge clk); while (!in_ch.ready);
    predicted = ring_step(act, data, arg);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_field(input string name, input logic [7:0] expected,
                             input logic [7:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  // stimulus
  initial begin
    traffic_mix_t     mix;
    int               seg_left;
    int               sent;
    int               held;
    int               roll;
    brb_pkg::action_t act;
    logic [7:0]       data;
    logic [7:0]       arg;

    mismatches   = 0;
    head_ptr     = 0;
    tail_ptr     = 0;
    send_stretch = 0;
    send_calm    = 1'b0;
    rst                   <= 1'b1;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= brb_pkg::ACT_PUSH;
    in_ch.push_byte       <= '0;
    in_ch.offset_or_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_action(directed_rows[i].act, directed_rows[i].data, directed_rows[i].arg,
                  directed_rows[i].typed, directed_rows[i].res);

    // random traffic in segments; the first one is mostly pushes
    mix      = MIX_FILL;
    seg_left = 300;
    for (sent = 0; sent < RANDOM_OPS; sent++) begin
      if (seg_left == 0) begin
        roll     = $urandom_range(0, 2);
        mix      = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
        seg_left = $urandom_range(20, 300);
      end
      seg_left--;
      held = ring_held();
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  act = (roll < 85) ? brb_pkg::ACT_PUSH
                                     : brb_pkg::action_t'($urandom_range(1, 3));
        MIX_DRAIN: act = (roll < 45) ? brb_pkg::ACT_POP : (roll < 65) ? brb_pkg::ACT_SKIP :
                         (roll < 85) ? brb_pkg::ACT_PEEK : brb_pkg::ACT_PUSH;
        default:   act = brb_pkg::action_t'($urandom_range(0, 3));
      endcase
      data = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (act == brb_pkg::ACT_PEEK) begin
        // in range, anywhere, or right at the fill edge
        if (roll < 45 && held > 0)
          arg = 8'($urandom_range(0, held - 1));
        else if (roll < 80)
          arg = 8'($urandom_range(0, 255));
        else begin
          case ($urandom_range(0, 3))
            0:       arg = 8'd0;
            1:       arg = (held > 0) ? 8'(held - 1) : 8'd0;
            2:       arg = (held > 255) ? 8'd255 : 8'(held);
            default: arg = 8'd255;
          endcase
        end
      end else if (act == brb_pkg::ACT_SKIP) begin
        if (roll < 50)
          arg = 8'($urandom_range(0, (held + 3 > 255) ? 255 : held + 3));
        else if (roll < 75)
          arg = 8'($urandom_range(0, 255));
        else
          arg = (roll < 83) ? 8'd0 : (roll < 91) ? 8'd255 :
                (held > 255) ? 8'd255 : 8'(held);
      end else begin
        arg = 8'($urandom_range(0, 255));
      end
      send_action(act, data, arg, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    // drain and let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random stalls, two long hold-offs, field-by-field compare
  initial begin
    int           gap;
    int           recv_stretch;
    bit           recv_calm;
    ring_result_t expected;
    ring_result_t got;

    results_taken = 0;
    recv_stretch  = 0;
    recv_calm     = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = draw_gap(recv_stretch, recv_calm);
      // hold off long enough that the sender backs up behind the block
      if (results_taken == 40 || results_taken == 800)
        gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_taken++;
      got = '{out_ch.read_byte, out_ch.ok, out_ch.skipped, out_ch.fill_count,
              out_ch.is_empty, out_ch.is_full};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %0h", $time, got);
        mismatches++;
      end else begin
        expected = pending_results.pop_front();
        check_field("read_byte",  expected.rd_byte,   got.rd_byte);
        check_field("ok",         8'(expected.ok),    8'(got.ok));
        check_field("skipped",    expected.skipped,   got.skipped);
        check_field("fill_count", expected.fill,      got.fill);
        check_field("is_empty",   8'(expected.empty), 8'(got.empty));
        check_field("is_full",    8'(expected.full),  8'(got.full));
      end
    end
  end

  // watchdog: too many cycles without any beat on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> byte_ring_buffer_with_peek.f
hdl/brb_pkg.sv
hdl/brb_if.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/brb_dp.sv
hdl/byte_ring_buffer_with_peek.sv
tb/sv/tb.sv
